// ===== sv/tos_pkg.sv =====
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types and codes of the timer ordered set.
// ----------------------------------------------------------------------------
package tos_pkg;

  localparam int DL_W   = 48;
  localparam int OW_W   = 16;
  localparam int KIND_W = 2;
  localparam int STS_W  = 3;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_DUP      = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd2;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;

  // one timer entry as held in a cell
  typedef struct packed {
    logic            used;
    logic [DL_W-1:0] deadline;
    logic [OW_W-1:0] owner;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic capture;  // latch compare flags against the incoming word
    logic ins;      // shift right where the new entry goes in
    logic del;      // shift left over the removed entry
  } cell_ctl_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EVAL
  } fsm_t;

endpackage

// ===== sv/tos_cell.sv =====
// ----------------------------------------------------------------------------
// tos_cell
// One slot of the sorted chain: holds an entry, its compare flags, and
// loads from its left neighbor, its right neighbor or the new entry when the chain shifts.
// ----------------------------------------------------------------------------
module tos_cell import tos_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cell_ctl_t       ctl,
  input  logic [DL_W-1:0] cap_key,
  input  logic [OW_W-1:0] cap_who,
  input  entry_t          new_ent,
  input  entry_t          lft_ent,
  input  logic            lft_gt,
  input  entry_t          rgt_ent,
  input  logic            seen,     // owner match at or before this cell
  output entry_t          ent,
  output logic            gt,       // empty, or deadline above the key
  output logic            eq,       // holds the key
  output logic            om        // owner matches
);

  entry_t ent_next;

  always_comb begin
    ent_next = ent;
    if (ctl.ins && gt) begin
      ent_next = lft_gt ? lft_ent : new_ent;
    end else if (ctl.del && seen) begin
      ent_next = rgt_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.used <= 1'b0;
    end else begin
      ent.used <= ent_next.used;
    end
    ent.deadline <= ent_next.deadline;
    ent.owner    <= ent_next.owner;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      gt <= !ent.used || (ent.deadline > cap_key);
      eq <= ent.used && (ent.deadline == cap_key);
      om <= ent.used && (ent.owner == cap_who);
    end
  end

endmodule

// ===== sv/tos_prefix_or.sv =====
// ----------------------------------------------------------------------------
// tos_prefix_or
// Inclusive prefix OR along the chain, log-depth parallel prefix.
// ----------------------------------------------------------------------------
module tos_prefix_or #(
  parameter int N = 64
) (
  input  logic [N-1:0] d,
  output logic [N-1:0] q
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LV+1];

  assign lvl[0] = d;

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign q = lvl[LV];

endmodule

// ===== sv/timer_ordered_set.sv =====
// ----------------------------------------------------------------------------
// timer_ordered_set
// Bounded ordered set of pending timers kept in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each input word is an insert, a delete by owner, or a query of the
// earliest deadline, and gives exactly one result word. Entries live in a
// row of CAPACITY cells sorted by deadline, smallest in cell 0, used cells
// packed from the low end. In the accept cycle (state FSM_IDLE) every
// cell compares its entry with the word's deadline and owner and latches
// the flags; in state FSM_EVAL the chain shifts (right of the insert
// point for an insert, left over the first owner match for a delete)
// and the result is written to the output register. The next word is
// taken only after the return to FSM_IDLE, so no word is accepted while
// one is under evaluation; FSM_EVAL stretches only while an earlier
// result still waits on m_tready. The valid marks reset at once, so
// there is no clearing pass. Kind 3 changes nothing and answers ok.
// ----------------------------------------------------------------------------
module timer_ordered_set import tos_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // deadline[47:0], owner[63:48]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // status[2:0], min_deadline[50:3],
                                 // min_owner[66:51], zero fill above
);

  // per-cell signals; cell i takes entries from cells i-1 and i+1, and seen from the prefix OR
  entry_t                ents [CAPACITY];
  logic   [CAPACITY-1:0] gts;
  logic   [CAPACITY-1:0] eqs;
  logic   [CAPACITY-1:0] oms;
  logic   [CAPACITY-1:0] seen;

  // the word under evaluation
  fsm_t              state, state_next;
  logic [KIND_W-1:0] op;
  logic [DL_W-1:0]   key;
  logic [OW_W-1:0]   who;
  entry_t            new_ent;

  cell_ctl_t ctl;
  logic      accept;
  logic      out_free;
  logic      dup, full, found;
  logic      load_out;
  logic [STS_W-1:0] sts;
  logic [DL_W-1:0]  mdl;
  logic [OW_W-1:0]  mown;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // global views of the latched flags and of the last cell
  assign dup   = |eqs;
  assign full  = ents[CAPACITY-1].used;
  assign found = seen[CAPACITY-1];

  assign new_ent = '{used: 1'b1, deadline: key, owner: who};

  tos_prefix_or #(.N(CAPACITY)) u_seen (
    .d (oms),
    .q (seen)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t lft_e, rgt_e;
    logic   lft_g;
    if (i == 0) begin : g_first
      assign lft_e = '0;
      assign lft_g = 1'b0;
    end else begin : g_left
      assign lft_e = ents[i-1];
      assign lft_g = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rgt_e = '0;
    end else begin : g_right
      assign rgt_e = ents[i+1];
    end

    tos_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .cap_key (s_tdata[DL_W-1:0]),
      .cap_who (s_tdata[DL_W+OW_W-1:DL_W]),
      .new_ent (new_ent),
      .lft_ent (lft_e),
      .lft_gt  (lft_g),
      .rgt_ent (rgt_e),
      .seen    (seen[i]),
      .ent     (ents[i]),
      .gt      (gts[i]),
      .eq      (eqs[i]),
      .om      (oms[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, chain commands and the result word
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ctl         = '0;
    load_out    = 1'b0;
    sts         = STS_OK;
    mdl         = '0;
    mown        = '0;
    case (state)
      FSM_IDLE: begin
        s_tready    = 1'b1;
        ctl.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        case (op)
          KIND_INSERT: begin
            if (dup) begin
              sts = STS_DUP;
            end else if (full) begin
              sts = STS_FULL;
            end
          end
          KIND_DELETE: begin
            if (!found) begin
              sts = STS_NOTFOUND;
            end
          end
          KIND_QUERY: begin
            if (!ents[0].used) begin
              sts = STS_EMPTY;
            end else begin
              mdl  = ents[0].deadline;
              mown = ents[0].owner;
            end
          end
          default: begin
            sts = STS_OK;
          end
        endcase
        if (out_free) begin
          load_out   = 1'b1;
          ctl.ins    = (op == KIND_INSERT) && !dup && !full;
          ctl.del    = (op == KIND_DELETE) && found;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // word under evaluation, captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_tuser;
      key <= s_tdata[DL_W-1:0];
      who <= s_tdata[DL_W+OW_W-1:DL_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'b0, mown, mdl, sts};
    end
  end

endmodule

// ===== dv/tos_order_check.sv =====
// ----------------------------------------------------------------------------
// tos_order_check
// Watches both stream channels of the timer ordered set, keeps its own copy
// of the held timers, and checks every result word against the prediction.
// ----------------------------------------------------------------------------
module tos_order_check import tos_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // deadline[47:0], owner[63:48]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // status[2:0], min_deadline[50:3],
                                 // min_owner[66:51], zero fill above
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [DL_W-1:0]  min_deadline;
    logic [OW_W-1:0]  min_owner;
  } timer_result_t;

  logic            held          [CAPACITY];
  logic [DL_W-1:0] held_deadline [CAPACITY];
  logic [OW_W-1:0] held_owner    [CAPACITY];

  timer_result_t due_results[$];
  int            errors = 0;

  assign fail_count = errors;

  // Earliest held entry, optionally only among one owner's entries; -1 if none.
  function automatic int earliest(input logic by_owner, input logic [OW_W-1:0] who);
    int best;
    best = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (held[i] && (!by_owner || held_owner[i] == who)) begin
        if (best < 0 || held_deadline[i] < held_deadline[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic timer_result_t apply_timer_word(input logic [KIND_W-1:0] kind,
                                                     input logic [DL_W-1:0]   dl,
                                                     input logic [OW_W-1:0]   who);
    timer_result_t res;
    int            free_slot;
    int            hit;
    logic          dup;
    res        = '0;
    res.status = STS_OK;
    case (kind)
      KIND_INSERT: begin
        free_slot = -1;
        dup       = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (held[i]) begin
            if (held_deadline[i] == dl) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        // duplicate wins over full
        if (dup) begin
          res.status = STS_DUP;
        end else if (free_slot < 0) begin
          res.status = STS_FULL;
        end else begin
          held[free_slot]          = 1'b1;
          held_deadline[free_slot] = dl;
          held_owner[free_slot]    = who;
        end
      end
      KIND_DELETE: begin
        hit = earliest(1'b1, who);
        if (hit < 0) res.status = STS_NOTFOUND;
        else         held[hit] = 1'b0;
      end
      KIND_QUERY: begin
        hit = earliest(1'b0, '0);
        if (hit < 0) begin
          res.status = STS_EMPTY;
        end else begin
          res.min_deadline = held_deadline[hit];
          res.min_owner    = held_owner[hit];
        end
      end
      default: ;  // unused kind: no change, ok with zero fields
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      foreach (held[i]) held[i] = 1'b0;
      due_results.delete();
    end else begin
      // result side first: a word's result never leaves in its accept cycle
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: word expected none actual %h", $time, m_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_tdata[2:0]));
          check_field("min_deadline", 64'(want.min_deadline), 64'(m_tdata[50:3]));
          check_field("min_owner", 64'(want.min_owner), 64'(m_tdata[66:51]));
          check_field("fill", 64'd0, 64'(m_tdata[71:67]));
        end
      end
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_timer_word(s_tuser, s_tdata[47:0], s_tdata[63:48]));
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the timer ordered set.
// ----------------------------------------------------------------------------
// A directed opener walks the corner cases (empty set, missing owner, extreme
// keys and owners, duplicate keys, one owner holding several timers, removal
// of the earliest entry, the unused kind). Random traffic follows in blocks
// that fill the store to the top, churn it, and drain it, under four
// flow-control phases. The checker beside the DUT predicts and compares;
// this module only drives words and back-pressure and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tos_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int BLOCK_WORDS = 125;    // 3 blocks x 4 phases ~ 1500 words
  localparam int STALL_LIMIT = 5000;   // cycles with no handshake on either side
  localparam int TAIL_CYCLES = 16;

  // kind value the block has no operation for
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // flow-control phases: none, sender idle, receiver stall, both
  localparam int IDLE_BY_PHASE  [4] = '{0, 83, 0, 29};
  localparam int STALL_BY_PHASE [4] = '{0, 0, 83, 29};

  // traffic blocks within a phase
  localparam int MODE_FILL  = 0;
  localparam int MODE_CHURN = 1;
  localparam int MODE_DRAIN = 2;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata  = '0;    // deadline[47:0], owner[63:48]
  logic [1:0]  s_tuser  = '0;    // kind[1:0]
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;          // status[2:0], min_deadline[50:3],
                                 // min_owner[66:51], zero fill above

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int fail_count;
  int pending;

  timer_ordered_set #(.CAPACITY(CAPACITY)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tos_order_check #(.CAPACITY(CAPACITY)) u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timer_ordered_set: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one word and hold it until taken. Called at a rising edge; valid is
  // only lowered when an idle cycle is inserted, so back-to-back words keep it
  // high with a single assignment per edge.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DL_W-1:0] dl,
                           input logic [OW_W-1:0] ow);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {ow, dl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Half the keys come from a narrow window so duplicates are common; a few
  // sit at the top of the range; the rest span all 48 bits.
  function automatic logic [DL_W-1:0] pick_deadline();
    int r;
    r = $urandom_range(9);
    if (r < 5)       return DL_W'($urandom_range(127));
    else if (r == 5) return {DL_W{1'b1}} - DL_W'($urandom_range(3));
    else             return DL_W'({$urandom, $urandom});
  endfunction

  // Small owner pool so deletes hit and owners repeat.
  function automatic logic [OW_W-1:0] pick_owner();
    if ($urandom_range(9) < 7) return OW_W'($urandom_range(15));
    else                       return OW_W'($urandom);
  endfunction

  initial begin
    int                r;
    int                ins_cut;
    int                del_cut;
    int                qry_cut;
    logic [KIND_W-1:0] kind;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed opener ----
    send_word(KIND_QUERY,  '0, '0);                       // empty set
    send_word(KIND_DELETE, '0, '0);                       // owner not found
    send_word(KIND_UNUSED, '0, '0);                       // unused kind
    send_word(KIND_INSERT, {DL_W{1'b1}}, {OW_W{1'b1}});   // top key, top owner
    send_word(KIND_QUERY,  '0, '0);
    send_word(KIND_INSERT, '0, '0);                       // zero key, zero owner
    send_word(KIND_QUERY,  '0, '0);
    send_word(KIND_INSERT, '0, 16'd5);                    // duplicate key
    // one owner holding three timers
    send_word(KIND_INSERT, 48'd300, 16'd7);
    send_word(KIND_INSERT, 48'd100, 16'd7);
    send_word(KIND_INSERT, 48'd200, 16'd7);
    send_word(KIND_DELETE, '0, '0);                       // earliest entry goes, rest stays
    send_word(KIND_QUERY,  '0, '0);
    send_word(KIND_DELETE, '0, 16'd7);                    // only owner 7's earliest goes
    send_word(KIND_QUERY,  '0, '0);
    send_word(KIND_DELETE, '0, {OW_W{1'b1}});
    send_word(KIND_DELETE, '0, {OW_W{1'b1}});             // already gone
    send_word(KIND_INSERT, 48'hAAAA_AAAA_AAAA, 16'h5555);
    send_word(KIND_INSERT, 48'h5555_5555_5555, 16'hAAAA);
    send_word(KIND_QUERY,  48'h1234_5678_9ABC, 16'hBEEF); // fields ignored
    send_word(KIND_UNUSED, 48'hFEDC_BA98_7654, 16'h3210);
    send_word(KIND_DELETE, '0, 16'd7);
    send_word(KIND_DELETE, '0, 16'h5555);
    send_word(KIND_DELETE, '0, 16'hAAAA);
    send_word(KIND_QUERY,  '0, '0);                       // owner 7's last timer remains

    // ---- random traffic ----
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct   = IDLE_BY_PHASE[ph];
      stall_pct <= STALL_BY_PHASE[ph];
      for (int blk = MODE_FILL; blk <= MODE_DRAIN; blk++) begin
        // fill pushes the store past full; drain empties it through deletes
        case (blk)
          MODE_FILL:  begin ins_cut = 85; del_cut = 92; qry_cut = 99; end
          MODE_CHURN: begin ins_cut = 45; del_cut = 80; qry_cut = 97; end
          default:    begin ins_cut = 15; del_cut = 80; qry_cut = 97; end
        endcase
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          r = $urandom_range(99);
          if (r < ins_cut)      kind = KIND_INSERT;
          else if (r < del_cut) kind = KIND_DELETE;
          else if (r < qry_cut) kind = KIND_QUERY;
          else                  kind = KIND_UNUSED;
          send_word(kind, pick_deadline(), pick_owner());
        end
      end
    end

    // ---- wind down ----
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("timer_ordered_set: match");
    end else begin
      $display("timer_ordered_set: mismatch");
    end
    $finish;
  end

endmodule
